>>> design/icp_pkg.sv
// Shared constants, register codes and coefficient tables of the iteration color palette.
package icp_pkg;

  // Parameter defaults
  localparam int COUNT_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 4;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE  = CFG_INDEX_W'(1);

  localparam int MAX_ITER_RESET = 100;

  // Palette codes
  localparam int PAL_W = 3;

  localparam logic [PAL_W-1:0] PAL_ONE   = PAL_W'(1);
  localparam logic [PAL_W-1:0] PAL_TWO   = PAL_W'(2);
  localparam logic [PAL_W-1:0] PAL_THREE = PAL_W'(3);
  localparam logic [PAL_W-1:0] PAL_FOUR  = PAL_W'(4);

  // Doubled coefficient times 255, and the channel term width
  localparam int COEF_W  = 13;
  localparam int TERM_W  = 13;
  localparam int PIXEL_W = 25;

  localparam logic [COEF_W-1:0] K_RED_STD = COEF_W'(18 * 255);
  localparam logic [COEF_W-1:0] K_RED_P4  = COEF_W'(32 * 255);
  localparam logic [COEF_W-1:0] K_GRN_P2  = COEF_W'(24 * 255);
  localparam logic [COEF_W-1:0] K_GRN_P3  = COEF_W'(30 * 255);
  localparam logic [COEF_W-1:0] K_GRN_P4  = COEF_W'(20 * 255);
  localparam logic [COEF_W-1:0] K_BLU_P2  = COEF_W'(13 * 255);
  localparam logic [COEF_W-1:0] K_BLU_P3  = COEF_W'(17 * 255);
  localparam logic [COEF_W-1:0] K_BLU_P4  = COEF_W'(19 * 255);

  function automatic logic [COEF_W-1:0] coef_red(input logic [PAL_W-1:0] pal);
    logic [COEF_W-1:0] k;
    unique case (pal)
      PAL_FOUR: k = K_RED_P4;
      default:  k = K_RED_STD;
    endcase
    return k;
  endfunction

  function automatic logic [COEF_W-1:0] coef_green(input logic [PAL_W-1:0] pal);
    logic [COEF_W-1:0] k;
    unique case (pal)
      PAL_THREE: k = K_GRN_P3;
      PAL_FOUR:  k = K_GRN_P4;
      default:   k = K_GRN_P2;
    endcase
    return k;
  endfunction

  function automatic logic [COEF_W-1:0] coef_blue(input logic [PAL_W-1:0] pal);
    logic [COEF_W-1:0] k;
    unique case (pal)
      PAL_THREE: k = K_BLU_P3;
      PAL_FOUR:  k = K_BLU_P4;
      default:   k = K_BLU_P2;
    endcase
    return k;
  endfunction

endpackage

>>> design/icp_front.sv
// Front end: count saturation and pipelined restoring divider forming t = count / limit.
module icp_front #(
  parameter int COUNT_BITS    = icp_pkg::COUNT_BITS_DEF,
  parameter int LIM_BITS      = icp_pkg::CFG_DATA_W,
  parameter int FRACTION_BITS = icp_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COUNT_BITS-1:0]    iteration_count,
  input  logic [LIM_BITS-1:0]      max_iterations,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [FRACTION_BITS:0]   q_t
);
  import icp_pkg::*;

  // one integer quotient bit plus one bit per fraction position
  localparam int STEPS = FRACTION_BITS + 1;

  logic [LIM_BITS-1:0]      lim_eff;
  logic [LIM_BITS-1:0]      c_sat;
  logic                     advance;

  logic                     valid [0:STEPS];
  logic [LIM_BITS-1:0]      rem   [0:STEPS];
  logic [FRACTION_BITS:0]   quo   [0:STEPS];

  logic [LIM_BITS:0]        trial  [1:STEPS];
  logic                     ge     [1:STEPS];
  logic [LIM_BITS-1:0]      rem_nx [1:STEPS];

  // a zero limit acts as one; count saturates to the limit
  assign lim_eff = (max_iterations == '0) ? LIM_BITS'(1) : max_iterations;
  assign c_sat   = (iteration_count > COUNT_BITS'(lim_eff)) ? lim_eff
                                                             : iteration_count[LIM_BITS-1:0];

  // whole pipe holds only when the last stage cannot hand off its word
  assign advance  = !(valid[STEPS] && q_full);
  assign in_ready = advance;
  assign q_push   = valid[STEPS] && !q_full;
  assign q_t      = quo[STEPS];

  // one compare and subtract per stage; remainder stays below the limit
  always_comb begin
    for (int k = 1; k <= STEPS; k++) begin
      trial[k]  = (k == 1) ? {1'b0, rem[k-1]} : {rem[k-1], 1'b0};
      ge[k]     = (trial[k] >= {1'b0, lim_eff});
      rem_nx[k] = ge[k] ? LIM_BITS'(trial[k] - {1'b0, lim_eff}) : trial[k][LIM_BITS-1:0];
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STEPS; k++) valid[k] <= 1'b0;
    end else if (advance) begin
      valid[0] <= in_valid;
      for (int k = 1; k <= STEPS; k++) valid[k] <= valid[k-1];
    end
  end

  // remainder and quotient bits
  always_ff @(posedge clk) begin
    if (advance) begin
      rem[0] <= c_sat;
      quo[0] <= '0;
      for (int k = 1; k <= STEPS; k++) begin
        rem[k] <= rem_nx[k];
        quo[k] <= {quo[k-1][FRACTION_BITS-1:0], ge[k]};
      end
    end
  end

endmodule

>>> design/icp_queue.sv
// Short FIFO of ratio words between the front end and the color back end.
module icp_queue #(
  parameter int WIDTH = icp_pkg::FRACTION_BITS_DEF + 1,
  parameter int DEPTH = icp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  import icp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_data  = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/icp_back.sv
// Back end: power products, scaled channel terms and palette packing into the output register.
module icp_back #(
  parameter int FRACTION_BITS = icp_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  logic [FRACTION_BITS:0]           q_t,
  output logic                             q_pop,
  input  logic [icp_pkg::PAL_W-1:0]        palette_select,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [icp_pkg::PIXEL_W-1:0]      pixel_color
);
  import icp_pkg::*;

  localparam int FW     = FRACTION_BITS + 1;
  localparam int PROD_W = 2 * FW;
  localparam int TPROD_W = COEF_W + FW;
  localparam logic [FRACTION_BITS:0] ONE_FIX = {1'b1, {FRACTION_BITS{1'b0}}};

  // fixed-point multiply, truncated; both operands at most 1.0
  function automatic logic [FRACTION_BITS:0] fmul(input logic [FRACTION_BITS:0] a,
                                                  input logic [FRACTION_BITS:0] b);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(a) * PROD_W'(b);
    return prod[2*FRACTION_BITS:FRACTION_BITS];
  endfunction

  // coefficient term, halved and truncated
  function automatic logic [TERM_W-1:0] term(input logic [COEF_W-1:0] k,
                                             input logic [FRACTION_BITS:0] p);
    logic [TPROD_W-1:0] prod;
    prod = TPROD_W'(k) * TPROD_W'(p);
    return prod[FRACTION_BITS+TERM_W:FRACTION_BITS+1];
  endfunction

  logic                   advance;
  logic [FRACTION_BITS:0] u_in;

  logic                   v1, v2, v3, v4;
  logic [FRACTION_BITS:0] t1, u1, pr1, puu1;
  logic [FRACTION_BITS:0] t2, pr2, pg2, pb2;
  logic [FRACTION_BITS:0] pr3, pg3, pb3;
  logic [TERM_W-1:0]      r4, g4, b4;
  logic [PIXEL_W-1:0]     r_w, g_w, b_w;
  logic [PIXEL_W-1:0]     color;

  // the whole back pipe moves whenever the output register is free or taken
  assign advance     = !out_valid || out_ready;
  assign q_pop       = advance && q_valid;
  assign u_in        = ONE_FIX - q_t;

  // stage valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= q_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // power products: red u*t^3, green u^2*t^2, blue u^3*t
  always_ff @(posedge clk) begin
    if (advance) begin
      t1   <= q_t;
      u1   <= u_in;
      pr1  <= fmul(u_in, q_t);
      puu1 <= fmul(u_in, u_in);

      t2  <= t1;
      pr2 <= fmul(pr1, t1);
      pg2 <= fmul(puu1, t1);
      pb2 <= fmul(puu1, u1);

      pr3 <= fmul(pr2, t2);
      pg3 <= fmul(pg2, t2);
      pb3 <= fmul(pb2, t2);

      r4 <= term(coef_red(palette_select), pr3);
      g4 <= term(coef_green(palette_select), pg3);
      b4 <= term(coef_blue(palette_select), pb3);

      pixel_color <= color;
    end
  end

  // palette packing, modulo the pixel width
  assign r_w = PIXEL_W'(r4);
  assign g_w = PIXEL_W'(g4);
  assign b_w = PIXEL_W'(b4);

  always_comb begin
    unique case (palette_select)
      PAL_ONE:   color = (r_w << 16) + ((r_w * r_w) << 6);
      PAL_THREE: color = (r_w << 16) + (g_w << 8) + b_w;
      PAL_FOUR:  color = (r_w << 16) + (g_w << 4) + b_w;
      default:   color = (r_w << 16) + (g_w << 2) + b_w;
    endcase
  end

endmodule

>>> design/iteration_color_palette_top.sv
// Top level of the iteration color palette: configuration registers and front/queue/back wiring.
//
// Takes one iteration count per cycle while in_ready is high and returns one packed pixel
// color per count, in order. The ratio count/limit comes from a restoring divider that
// resolves one quotient bit per pipeline stage (FRACTION_BITS + 1 stages, behind one input
// register). Each word then passes through the queue. The channel powers, coefficient terms
// and palette packing follow in five more registered steps. A new word can be taken every
// cycle unless the queue is full and the last divider stage holds a word. A four-word queue
// between the divider and the color stages lets either side stall on its own. Configuration
// writes are taken every cycle; change them only while no word is in flight.
module iteration_color_palette_top #(
  parameter int COUNT_BITS    = icp_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = icp_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [COUNT_BITS-1:0]           iteration_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [icp_pkg::PIXEL_W-1:0]     pixel_color,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [icp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [icp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import icp_pkg::*;

  localparam int LIM_BITS = (COUNT_BITS < CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;

  logic [LIM_BITS-1:0]    max_iterations;
  logic [PAL_W-1:0]       palette_select;

  logic                   q_full;
  logic                   q_push;
  logic [FRACTION_BITS:0] q_push_t;
  logic                   q_valid;
  logic                   q_pop;
  logic [FRACTION_BITS:0] q_t;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= LIM_BITS'(MAX_ITER_RESET);
      palette_select <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_ITER: max_iterations <= cfg_data[LIM_BITS-1:0];
        REG_PALETTE:  palette_select <= cfg_data[PAL_W-1:0];
        default: ;
      endcase
    end
  end

  icp_front #(
    .COUNT_BITS   (COUNT_BITS),
    .LIM_BITS     (LIM_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .iteration_count(iteration_count),
    .max_iterations (max_iterations),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_t            (q_push_t)
  );

  icp_queue #(
    .WIDTH(FRACTION_BITS + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_t),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_t)
  );

  icp_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_t           (q_t),
    .q_pop         (q_pop),
    .palette_select(palette_select),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_color   (pixel_color)
  );

endmodule

>>> verif/tb_iteration_color_palette_top.sv
// Self-checking testbench for the iteration color palette: directed, random and stall tests.
`timescale 1ns / 100ps

module tb_iteration_color_palette_top;
  import icp_pkg::*;

  localparam int FRAC_BITS = FRACTION_BITS_DEF;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

  // Unused register slots; writes there must leave the color math alone
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = CFG_INDEX_W'(3);

  // Doubled channel coefficients per palette
  localparam logic [63:0] C2_RED_STD = 64'd18;
  localparam logic [63:0] C2_RED_P4  = 64'd32;
  localparam logic [63:0] C2_GRN_P2  = 64'd24;
  localparam logic [63:0] C2_GRN_P3  = 64'd30;
  localparam logic [63:0] C2_GRN_P4  = 64'd20;
  localparam logic [63:0] C2_BLU_P2  = 64'd13;
  localparam logic [63:0] C2_BLU_P3  = 64'd17;
  localparam logic [63:0] C2_BLU_P4  = 64'd19;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [COUNT_BITS_DEF-1:0] iteration_count;
  logic                   out_valid;
  logic                   out_ready;
  logic [PIXEL_W-1:0]     pixel_color;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow of the block's registers
  logic [15:0]      limit_reg;
  logic [PAL_W-1:0] palette_reg;

  logic [PIXEL_W-1:0] expected_colors[$];
  int error_count;
  int colors_checked;
  int setting_count;
  logic [7:0] palettes_seen;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;

  iteration_color_palette_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .iteration_count (iteration_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pixel_color     (pixel_color),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Timeout waiting for the pipeline to finish");
    $display("Test completed with failures");
    $finish;
  end

  // One channel level: u^nu * t^nt in fixed point, times 2C * 255, halved and truncated
  function automatic logic [63:0] channel_level(input logic [63:0] coef2, input logic [63:0] u,
                                                input logic [63:0] t, input int nu,
                                                input int nt);
    logic [63:0] prod;
    prod = u;
    for (int k = 1; k < nu; k++) prod = (prod * u) >> FRAC_BITS;
    for (int k = 0; k < nt; k++) prod = (prod * t) >> FRAC_BITS;
    return (coef2 * 64'd255 * prod) >> (FRAC_BITS + 1);
  endfunction

  // Color for one count under the current register settings
  function automatic logic [PIXEL_W-1:0] predict_color(input logic [15:0] cnt);
    logic [63:0] lim, c, t, u, r, g, b, color_sum;
    lim = {48'd0, limit_reg};
    if (lim == 64'd0) lim = 64'd1;
    c = {48'd0, cnt};
    if (c > lim) c = lim;
    t = (c << FRAC_BITS) / lim;
    if (t > ONE_Q) t = ONE_Q;
    u = ONE_Q - t;
    case (palette_reg)
      PAL_ONE: begin
        r = channel_level(C2_RED_STD, u, t, 1, 3);
        color_sum = (r << 16) + (r << 6) * r;
      end
      PAL_THREE: begin
        r = channel_level(C2_RED_STD, u, t, 1, 3);
        g = channel_level(C2_GRN_P3, u, t, 2, 2);
        b = channel_level(C2_BLU_P3, u, t, 3, 1);
        color_sum = (r << 16) + (g << 8) + b;
      end
      PAL_FOUR: begin
        r = channel_level(C2_RED_P4, u, t, 1, 3);
        g = channel_level(C2_GRN_P4, u, t, 2, 2);
        b = channel_level(C2_BLU_P4, u, t, 3, 1);
        color_sum = (r << 16) + (g << 4) + b;
      end
      default: begin
        // palette two and every unlisted code
        r = channel_level(C2_RED_STD, u, t, 1, 3);
        g = channel_level(C2_GRN_P2, u, t, 2, 2);
        b = channel_level(C2_BLU_P2, u, t, 3, 1);
        color_sum = (r << 16) + (g << 2) + b;
      end
    endcase
    return color_sum[PIXEL_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Output ready: long hold-off when asked, random stalls otherwise
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Color checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected color word 0x%07h", pixel_color));
      end else begin
        logic [PIXEL_W-1:0] want;
        want = expected_colors.pop_front();
        colors_checked++;
        if (pixel_color !== want)
          report_mismatch($sformatf("pixel_color 0x%07h, expected 0x%07h", pixel_color, want));
      end
    end
  end

  // Offer one count; returns once the word has been taken
  task automatic send_count(input logic [15:0] cnt);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    iteration_count <= cnt;
    do @(posedge clk); while (!in_ready);
    expected_colors.push_back(predict_color(cnt));
    palettes_seen[palette_reg] = 1'b1;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  // Register write; only called with nothing in flight
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_ITER: limit_reg = data;
      REG_PALETTE:  palette_reg = data[PAL_W-1:0];
      default: ;
    endcase
    setting_count++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_palette(input int pal);
    write_reg(REG_PALETTE, {(CFG_DATA_W-PAL_W)'($urandom_range(0, 8191)), PAL_W'(pal)});
  endtask

  function automatic logic [15:0] pick_limit();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8)  return 16'd1;
    if (sel < 12) return 16'd2;
    if (sel < 20) return 16'hFFFF;
    if (sel < 24) return 16'd0;
    if (sel < 70) return 16'($urandom_range(3, 400));
    return 16'($urandom_range(401, 65535));
  endfunction

  // Mostly counts inside the limit, some beyond it, some at the ends
  function automatic logic [15:0] pick_count();
    int sel;
    int lim;
    sel = $urandom_range(99);
    lim = (limit_reg == 16'd0) ? 1 : int'(limit_reg);
    if (sel < 70) return 16'($urandom_range(0, lim));
    if (sel < 85) return 16'($urandom_range(0, 65535));
    if (sel < 90) return 16'(lim);
    if (sel < 94) return 16'd0;
    if (sel < 97) return 16'hFFFF;
    return 16'(lim + 1);
  endfunction

  // Reset values, palette codes and the ends of the count range
  task automatic test_directed();
    send_count(16'd0);
    send_count(16'd75);
    send_count(16'd100);
    send_count(16'd101);
    send_count(16'hFFFF);
    release_input();
    wait_drained();
    for (int p = 1; p <= 4; p++) begin
      set_palette(p);
      send_count(16'd25);
      send_count(16'd50);
      send_count(16'd75);
      release_input();
      wait_drained();
    end
    for (int p = 5; p <= 7; p++) begin
      set_palette(p);
      send_count(16'd40);
      release_input();
      wait_drained();
    end
    // zero limit acts as one
    write_reg(REG_MAX_ITER, 16'd0);
    set_palette(2);
    send_count(16'd0);
    send_count(16'd1);
    send_count(16'hFFFF);
    release_input();
    wait_drained();
    write_reg(REG_MAX_ITER, 16'hFFFF);
    send_count(16'd0);
    send_count(16'h8000);
    send_count(16'hBFFF);
    send_count(16'hFFFF);
    release_input();
    wait_drained();
  endtask

  // Random counts under changing settings, one idle pattern per call
  task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        if (i > 0) release_input();
        wait_drained();
        write_reg(REG_MAX_ITER, pick_limit());
        set_palette($urandom_range(0, 7));
      end
      send_count(pick_count());
    end
    release_input();
    wait_drained();
  endtask

  // Output held off for a long stretch while input keeps coming
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_MAX_ITER, 16'd255);
    set_palette(3);
    rx_hold_cycles = 300;
    for (int i = 0; i < 60; i++) send_count(pick_count());
    release_input();
    wait_drained();
  endtask

  // Sender stops mid-stream until every color is back
  task automatic test_input_pause();
    tx_idle_pct = 10;
    rx_idle_pct = 30;
    set_palette(1);
    for (int i = 0; i < 20; i++) send_count(pick_count());
    release_input();
    wait_drained();
    set_palette(4);
    for (int i = 0; i < 20; i++) send_count(pick_count());
    release_input();
    wait_drained();
  endtask

  // Writes to unused register slots
  task automatic test_spare_registers();
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 65535)));
    for (int i = 0; i < 12; i++) send_count(pick_count());
    release_input();
    wait_drained();
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    iteration_count = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    limit_reg       = 16'(MAX_ITER_RESET);
    palette_reg     = '0;
    error_count     = 0;
    colors_checked  = 0;
    setting_count   = 0;
    palettes_seen   = '0;
    tx_idle_pct     = 23;
    rx_idle_pct     = 84;
    rx_hold_cycles  = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(160, 23, 84);
    test_random(160, 84, 23);
    test_random(160, 0, 0);
    test_output_stall();
    test_input_pause();
    test_spare_registers();

    // let any stray word show up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (40) @(posedge clk);
    if (expected_colors.size() != 0)
      report_mismatch($sformatf("%0d colors never arrived", expected_colors.size()));

    $display("Checked %0d colors across %0d register writes, palette codes seen %b",
             colors_checked, setting_count, palettes_seen);
    $display("Covered saturation, zero limit, all palette codes, random stalls and long hold-off");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> iteration_color_palette_top.f
design/icp_pkg.sv
design/icp_front.sv
design/icp_queue.sv
design/icp_back.sv
design/iteration_color_palette_top.sv
verif/tb_iteration_color_palette_top.sv
